// ===== rtl/core/gtpr_pkg.sv =====
// Package for the glyph text pixel renderer: widths, register codes, item word type
// and the 6x7 font tables with their lookup functions. No dependencies.
package gtpr_pkg;

    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_COLS   = 6;
    localparam int FONT_ENTRIES = 41;

    localparam int ROW_W      = $clog2(GLYPH_ROWS);
    localparam int COL_W      = $clog2(GLYPH_COLS + 1);   // glyph columns plus spacer
    localparam int FONT_IDX_W = $clog2(FONT_ENTRIES);

    localparam int CODE_W   = 8;
    localparam int COORD_W  = 13;
    localparam int COLOR_W  = 8;
    localparam int PEN_W    = 16;
    localparam int XPOS_W   = PEN_W + 1;
    localparam int YPOS_W   = COORD_W + 1;
    localparam int SIZE_W   = 13;
    localparam int PITCH_W  = 14;
    localparam int PROD_W   = SIZE_W + PITCH_W;
    localparam int OFFSET_W = 25;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 2'd2;

    localparam logic [SIZE_W-1:0]  FB_WIDTH_RST   = 13'd320;
    localparam logic [SIZE_W-1:0]  FB_HEIGHT_RST  = 13'd200;
    localparam logic [PITCH_W-1:0] LINE_PITCH_RST = 14'd320;

    localparam logic [XPOS_W-1:0] PEN_ADVANCE = XPOS_W'(GLYPH_COLS + 1);
    localparam logic [PEN_W-1:0]  PEN_MAX     = 16'h7FFF;

    localparam logic [CODE_W-1:0] CODE_LOWER_A = 8'h61;
    localparam logic [CODE_W-1:0] CODE_LOWER_Z = 8'h7A;
    localparam logic [CODE_W-1:0] CASE_DELTA   = 8'h20;

    // entry of the space character, which is all clear
    localparam logic [FONT_IDX_W-1:0] BLANK_GLYPH = FONT_IDX_W'(FONT_ENTRIES - 1);

    // one queued character, already resolved to glyph and clip masks
    typedef struct packed {
        logic [COORD_W-1:0]    pen_lo;
        logic [COORD_W-1:0]    row_y;
        logic [COLOR_W-1:0]    fg;
        logic [COLOR_W-1:0]    bg;
        logic [FONT_IDX_W-1:0] glyph;
        logic [GLYPH_ROWS-1:0] row_mask;
        logic [GLYPH_COLS:0]   col_mask;   // top bit is the spacer column
    } item_t;

    localparam logic [CODE_W-1:0] FONT_CODES [FONT_ENTRIES] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h3A, 8'h2D, 8'h2B, 8'h2F, 8'h20
    };

    localparam logic [GLYPH_COLS-1:0] FONT_BITS [FONT_ENTRIES][GLYPH_ROWS] = '{
        '{6'h1E, 6'h33, 6'h33, 6'h3F, 6'h33, 6'h33, 6'h00},  // A
        '{6'h3E, 6'h33, 6'h3E, 6'h33, 6'h33, 6'h3E, 6'h00},  // B
        '{6'h1E, 6'h33, 6'h30, 6'h30, 6'h33, 6'h1E, 6'h00},  // C
        '{6'h3C, 6'h36, 6'h33, 6'h33, 6'h36, 6'h3C, 6'h00},  // D
        '{6'h3F, 6'h30, 6'h3E, 6'h30, 6'h30, 6'h3F, 6'h00},  // E
        '{6'h3F, 6'h30, 6'h3E, 6'h30, 6'h30, 6'h30, 6'h00},  // F
        '{6'h1E, 6'h33, 6'h30, 6'h37, 6'h33, 6'h1E, 6'h00},  // G
        '{6'h33, 6'h33, 6'h3F, 6'h33, 6'h33, 6'h33, 6'h00},  // H
        '{6'h1E, 6'h0C, 6'h0C, 6'h0C, 6'h0C, 6'h1E, 6'h00},  // I
        '{6'h07, 6'h03, 6'h03, 6'h03, 6'h33, 6'h1E, 6'h00},  // J
        '{6'h33, 6'h36, 6'h3C, 6'h36, 6'h33, 6'h33, 6'h00},  // K
        '{6'h30, 6'h30, 6'h30, 6'h30, 6'h30, 6'h3F, 6'h00},  // L
        '{6'h33, 6'h3F, 6'h3F, 6'h33, 6'h33, 6'h33, 6'h00},  // M
        '{6'h33, 6'h3B, 6'h3F, 6'h37, 6'h33, 6'h33, 6'h00},  // N
        '{6'h1E, 6'h33, 6'h33, 6'h33, 6'h33, 6'h1E, 6'h00},  // O
        '{6'h3E, 6'h33, 6'h33, 6'h3E, 6'h30, 6'h30, 6'h00},  // P
        '{6'h1E, 6'h33, 6'h33, 6'h33, 6'h37, 6'h1F, 6'h00},  // Q
        '{6'h3E, 6'h33, 6'h33, 6'h3E, 6'h36, 6'h33, 6'h00},  // R
        '{6'h1F, 6'h30, 6'h1E, 6'h03, 6'h33, 6'h1E, 6'h00},  // S
        '{6'h3F, 6'h0C, 6'h0C, 6'h0C, 6'h0C, 6'h0C, 6'h00},  // T
        '{6'h33, 6'h33, 6'h33, 6'h33, 6'h33, 6'h1E, 6'h00},  // U
        '{6'h33, 6'h33, 6'h33, 6'h33, 6'h1E, 6'h0C, 6'h00},  // V
        '{6'h33, 6'h33, 6'h33, 6'h3F, 6'h3F, 6'h33, 6'h00},  // W
        '{6'h33, 6'h33, 6'h1E, 6'h1E, 6'h33, 6'h33, 6'h00},  // X
        '{6'h33, 6'h33, 6'h1E, 6'h0C, 6'h0C, 6'h0C, 6'h00},  // Y
        '{6'h3F, 6'h03, 6'h0E, 6'h18, 6'h30, 6'h3F, 6'h00},  // Z
        '{6'h1E, 6'h33, 6'h37, 6'h3B, 6'h33, 6'h1E, 6'h00},  // 0
        '{6'h0C, 6'h1C, 6'h0C, 6'h0C, 6'h0C, 6'h1E, 6'h00},  // 1
        '{6'h1E, 6'h33, 6'h03, 6'h0E, 6'h18, 6'h3F, 6'h00},  // 2
        '{6'h3F, 6'h03, 6'h0E, 6'h03, 6'h33, 6'h1E, 6'h00},  // 3
        '{6'h06, 6'h0E, 6'h1E, 6'h36, 6'h3F, 6'h06, 6'h00},  // 4
        '{6'h3F, 6'h30, 6'h3E, 6'h03, 6'h33, 6'h1E, 6'h00},  // 5
        '{6'h1E, 6'h30, 6'h3E, 6'h33, 6'h33, 6'h1E, 6'h00},  // 6
        '{6'h3F, 6'h03, 6'h06, 6'h0C, 6'h18, 6'h18, 6'h00},  // 7
        '{6'h1E, 6'h33, 6'h1E, 6'h33, 6'h33, 6'h1E, 6'h00},  // 8
        '{6'h1E, 6'h33, 6'h33, 6'h1F, 6'h03, 6'h1E, 6'h00},  // 9
        '{6'h00, 6'h0C, 6'h00, 6'h00, 6'h0C, 6'h00, 6'h00},  // colon
        '{6'h00, 6'h00, 6'h00, 6'h1E, 6'h00, 6'h00, 6'h00},  // minus
        '{6'h00, 6'h0C, 6'h0C, 6'h3F, 6'h0C, 6'h0C, 6'h00},  // plus
        '{6'h03, 6'h06, 6'h0C, 6'h18, 6'h30, 6'h20, 6'h00},  // slash
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00}   // space
    };

    // folds lowercase, unknown codes map to the blank entry
    function automatic logic [FONT_IDX_W-1:0] find_glyph(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]     folded;
        logic [FONT_IDX_W-1:0] idx;
        folded = code;
        if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z)
            folded = code - CASE_DELTA;
        idx = BLANK_GLYPH;
        for (int i = FONT_ENTRIES - 1; i >= 0; i--)
        begin
            if (FONT_CODES[i] == folded)
                idx = FONT_IDX_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [FONT_IDX_W-1:0] idx,
                                                        input logic [ROW_W-1:0] row);
        return FONT_BITS[idx][row];
    endfunction

endpackage

// ===== rtl/core/gtpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/gtpr_intake.sv =====
// Intake stage: pen tracking, font lookup and clip masks for one character word.
// Depends on gtpr_pkg.
module gtpr_intake
    import gtpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [CODE_W-1:0]         char_code,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] row_y,
    input  logic [COLOR_W-1:0]        fg_color,
    input  logic [COLOR_W-1:0]        bg_color,
    input  logic                      first_char,
    input  logic [SIZE_W-1:0]         fb_width,
    input  logic [SIZE_W-1:0]         fb_height,
    output item_t                     item
);

    logic [PEN_W-1:0]  pen_reg;
    logic [PEN_W-1:0]  pen_next;
    logic [PEN_W-1:0]  pen_cur;
    logic [XPOS_W-1:0] pen_sum;
    logic [XPOS_W-1:0] x_pos;
    logic [YPOS_W-1:0] y_pos;

    assign pen_cur = first_char ? {{(PEN_W - COORD_W){start_x[COORD_W-1]}}, start_x}
                                : pen_reg;

    // pen never drops below the lowest start_x, so only the top end saturates
    assign pen_sum  = {pen_cur[PEN_W-1], pen_cur} + PEN_ADVANCE;
    assign pen_next = (!pen_sum[XPOS_W-1] && pen_sum[PEN_W-1]) ? PEN_MAX
                                                               : pen_sum[PEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pen_reg <= '0;
        else if (accept)
            pen_reg <= pen_next;
    end

    always_comb
    begin
        item.pen_lo = pen_cur[COORD_W-1:0];
        item.row_y  = row_y;
        item.fg     = fg_color;
        item.bg     = bg_color;
        item.glyph  = find_glyph(char_code);
        for (int c = 0; c <= GLYPH_COLS; c++)
        begin
            x_pos = {pen_cur[PEN_W-1], pen_cur} + XPOS_W'(c);
            item.col_mask[c] = !x_pos[XPOS_W-1] &&
                               (x_pos < {{(XPOS_W - SIZE_W){1'b0}}, fb_width});
        end
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            y_pos = {row_y[COORD_W-1], row_y} + YPOS_W'(r);
            item.row_mask[r] = !y_pos[YPOS_W-1] && (y_pos[SIZE_W-1:0] < fb_height);
        end
    end

endmodule

// ===== rtl/core/gtpr_raster.sv =====
// Raster sequencer: walks the 49 pixel slots of each queued character, drops clipped
// pixels, forms offsets and drives the output register. Depends on gtpr_pkg.
module gtpr_raster
    import gtpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    output logic                  rd_en,
    input  item_t                 rd_item,
    input  logic [PITCH_W-1:0]    line_pitch,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OFFSET_W-1:0]   pixel_offset,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  last_pixel
);

    logic               s1_valid_reg, s1_valid_next;
    logic               cur_valid_reg, cur_valid_next;
    item_t              cur_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               spacer_reg;

    logic               en;
    logic               cand_final;
    logic               load;
    logic               kept;
    logic               later;
    logic               rows_after;
    logic               cols_after;
    logic [GLYPH_COLS-1:0] bits;
    logic [COL_W-1:0]   col_eff;

    logic               a_valid_reg;
    logic               a_last_reg;
    logic [SIZE_W-1:0]  a_x_reg;
    logic [SIZE_W-1:0]  a_y_reg;
    logic [COLOR_W-1:0] a_color_reg;

    logic               b_valid_reg;
    logic               b_last_reg;
    logic [SIZE_W-1:0]  b_x_reg;
    logic [PROD_W-1:0]  b_prod_reg;
    logic [COLOR_W-1:0] b_color_reg;

    logic               o_valid_reg;

    // pipe holds while the output word is stalled; only an empty read slot still fills
    assign en         = !(o_valid_reg && out_stall);
    assign cand_final = spacer_reg && (row_reg == ROW_W'(GLYPH_ROWS - 1));
    assign load       = en && s1_valid_reg && (!cur_valid_reg || cand_final);
    assign rd_en      = q_not_empty && (!s1_valid_reg || load);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
            s1_valid_next = 1'b1;
        else if (load)
            s1_valid_next = 1'b0;
        cur_valid_next = cur_valid_reg;
        if (load)
            cur_valid_next = 1'b1;
        else if (en && cand_final)
            cur_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cur_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            spacer_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            cur_valid_reg <= cur_valid_next;
            if (load)
            begin
                row_reg    <= '0;
                col_reg    <= '0;
                spacer_reg <= 1'b0;
            end
            else if (en && cur_valid_reg)
            begin
                if (spacer_reg)
                    row_reg <= row_reg + 1'b1;
                else if (col_reg == COL_W'(GLYPH_COLS - 1))
                begin
                    col_reg <= '0;
                    if (row_reg == ROW_W'(GLYPH_ROWS - 1))
                    begin
                        row_reg    <= '0;
                        spacer_reg <= 1'b1;
                    end
                    else
                        row_reg <= row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= rd_item;
    end

    // clip and last-pixel decision from the per-item masks
    always_comb
    begin
        col_eff    = spacer_reg ? COL_W'(GLYPH_COLS) : col_reg;
        kept       = cur_reg.row_mask[row_reg] && cur_reg.col_mask[col_eff];
        rows_after = 1'b0;
        cols_after = 1'b0;
        for (int i = 0; i < GLYPH_ROWS; i++)
        begin
            if (i > int'(row_reg))
                rows_after = rows_after | cur_reg.row_mask[i];
        end
        for (int j = 0; j < GLYPH_COLS; j++)
        begin
            if (j > int'(col_reg))
                cols_after = cols_after | cur_reg.col_mask[j];
        end
        if (spacer_reg)
            later = cur_reg.col_mask[GLYPH_COLS] && rows_after;
        else
            later = (cur_reg.row_mask[row_reg] && cols_after) ||
                    (rows_after && (|cur_reg.col_mask[GLYPH_COLS-1:0])) ||
                    (cur_reg.col_mask[GLYPH_COLS] && (|cur_reg.row_mask));
        bits = glyph_row(cur_reg.glyph, row_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= cur_valid_reg && kept;
            b_valid_reg <= a_valid_reg;
            o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_last_reg  <= !later;
            a_x_reg     <= cur_reg.pen_lo + {{(SIZE_W - COL_W){1'b0}}, col_eff};
            a_y_reg     <= cur_reg.row_y + {{(SIZE_W - ROW_W){1'b0}}, row_reg};
            if (spacer_reg || !bits[COL_W'(GLYPH_COLS - 1) - col_reg])
                a_color_reg <= cur_reg.bg;
            else
                a_color_reg <= cur_reg.fg;

            b_last_reg  <= a_last_reg;
            b_x_reg     <= a_x_reg;
            b_prod_reg  <= a_y_reg * line_pitch;
            b_color_reg <= a_color_reg;

            last_pixel   <= b_last_reg;
            pixel_offset <= b_prod_reg[OFFSET_W-1:0] +
                            {{(OFFSET_W - SIZE_W){1'b0}}, b_x_reg};
            pixel_color  <= b_color_reg;
        end
    end

    assign out_valid = o_valid_reg;

endmodule

// ===== rtl/core/glyph_text_pixel_renderer.sv =====
// Top level of the glyph text pixel renderer: configuration registers, the
// character queue held in a RAM, and the intake and raster stages. Depends on gtpr_pkg.

// Draws text one character word at a time with a fixed 6x7 font (A-Z, 0-9,
// colon, minus, plus, slash, space; lowercase folds to uppercase, anything
// else draws blank). Each character yields up to 49 pixel words: the 42 glyph
// pixels row by row, left to right, then a 7-pixel background spacer column
// right of the glyph. Pixels outside fb_width x fb_height are dropped;
// last_pixel marks the final word of a character, and a character that is
// fully clipped sends nothing. pixel_offset is y*line_pitch + x, low 25 bits.
// The pen starts at start_x when first_char is set and moves right by 7 per
// character, saturating at +32767. Throughput: the sequencer steps through
// every pixel slot of a character, clipped or not, one slot per cycle unless
// the output is stalled; a queued character follows the one before without a gap.
// Accepted characters wait in a QUEUE_DEPTH-entry RAM, so in_stall rises only
// when that queue is full. A character passes the queue RAM, the sequencer and
// the a, b and output registers before its first pixel word. Configuration
// writes take effect at once and must be made while no character is in flight.
module glyph_text_pixel_renderer
    import gtpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,

    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    // character words
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CODE_W-1:0]         char_code,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] row_y,
    input  logic [COLOR_W-1:0]        fg_color,
    input  logic [COLOR_W-1:0]        bg_color,
    input  logic                      first_char,

    // pixel words
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [OFFSET_W-1:0]       pixel_offset,
    output logic [COLOR_W-1:0]        pixel_color,
    output logic                      last_pixel
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SIZE_W-1:0]  fb_width_reg;
    logic [SIZE_W-1:0]  fb_height_reg;
    logic [PITCH_W-1:0] line_pitch_reg;

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               accept;
    logic               rd_en;
    item_t              wr_item;
    item_t              rd_item;

    // register file; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg   <= FB_WIDTH_RST;
            fb_height_reg  <= FB_HEIGHT_RST;
            line_pitch_reg <= LINE_PITCH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FB_WIDTH:   fb_width_reg   <= cfg_data[SIZE_W-1:0];
                REG_FB_HEIGHT:  fb_height_reg  <= cfg_data[SIZE_W-1:0];
                REG_LINE_PITCH: line_pitch_reg <= cfg_data[PITCH_W-1:0];
                default:        ;
            endcase
        end
    end

    // queue control; a read only targets entries already written, so no bypass
    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (accept && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!accept && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    gtpr_intake u_intake (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_code  (char_code),
        .start_x    (start_x),
        .row_y      (row_y),
        .fg_color   (fg_color),
        .bg_color   (bg_color),
        .first_char (first_char),
        .fb_width   (fb_width_reg),
        .fb_height  (fb_height_reg),
        .item       (wr_item)
    );

    gtpr_ram #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_item),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_item)
    );

    gtpr_raster u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (count_reg != '0),
        .rd_en        (rd_en),
        .rd_item      (rd_item),
        .line_pitch   (line_pitch_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_offset (pixel_offset),
        .pixel_color  (pixel_color),
        .last_pixel   (last_pixel)
    );

endmodule
